@@ rtl/fts_pkg.sv @@
package fts_pkg;

    localparam int FLOAT_W   = 32;
    localparam int FACTOR_W  = 21;
    localparam int NUM_W     = 26;
    localparam int DIV_W     = 31;
    localparam int MANT_W    = 24;
    localparam int FRAC_W    = 23;
    localparam int EXPF_W    = 8;
    localparam int PRE_W     = 5;
    localparam int SHIFT_W   = 5;
    localparam int EXP_W     = 10;
    localparam int PROD_W    = MANT_W + FACTOR_W;
    localparam int MAG_W     = 25;

    localparam int EXP_BIAS     = 127;
    localparam int EXP_LIMIT    = 23;
    localparam int DIV_MAX_LOG2 = 30;

    localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(1);
    localparam logic [MAG_W-1:0]    SAT_MAG      = MAG_W'(1) << 24;

    // ceil(log2(f)); 0 for f of 0 or 1
    function automatic logic [PRE_W-1:0] preshift_of(input logic [FACTOR_W-1:0] f);
        logic [PRE_W-1:0] top;
        logic             pow2;
        top  = '0;
        pow2 = ((f & (f - FACTOR_W'(1))) == '0);
        for (int i = 0; i < FACTOR_W; i++)
        begin
            if (f[i])
            begin
                top = PRE_W'(i);
            end
        end
        if (f <= FACTOR_W'(1))
        begin
            return '0;
        end
        return pow2 ? top : top + PRE_W'(1);
    endfunction

endpackage

@@ rtl/fts_ifs.sv @@
interface fts_in_if;
    logic                            valid;
    logic                            ready;
    logic [fts_pkg::FLOAT_W-1:0]     float_bits;

    modport source (output valid, output float_bits, input ready);
    modport sink   (input valid, input float_bits, output ready);
endinterface

interface fts_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [fts_pkg::NUM_W-1:0] numerator;
    logic [fts_pkg::DIV_W-1:0]       divider;

    modport source (output valid, output numerator, output divider, input ready);
    modport sink   (input valid, input numerator, input divider, output ready);
endinterface

@@ rtl/float32_to_scaled_fraction.sv @@
// Float32 to scaled fraction converter.
// flt  : sink channel, one IEEE-754 single word per handshake (valid/ready).
// frac : source channel, one word per input word: signed numerator and a
//        power-of-two divider, numerator/divider ~ float * scale_factor.
// cfg_we/cfg_wdata: writes scale_factor (reset value 1); change it only
//        while no word is in flight.
// Throughput: one word per cycle while frac.ready is high; four
//        register stages (decode, mantissa align, 24x21 multiply,
//        preshift/sign/output register).
// Each stage holds its own valid bit and loads when empty or when the
// stage after it moves, so bubbles are squeezed out during a stall and
// flt.ready stays high until all four stages hold a word.
// When frac.ready is low the output word holds; nothing is dropped or
// repeated.
// Reset (rst_n low, asynchronous) empties the pipeline and sets
// scale_factor to 1.
module float32_to_scaled_fraction (
    input  logic                              clk,
    input  logic                              rst_n,
    fts_in_if.sink                            flt,
    fts_out_if.source                         frac,
    input  logic                              cfg_we,
    input  logic [fts_pkg::FACTOR_W-1:0]      cfg_wdata
);

    localparam int MW = fts_pkg::MANT_W;
    localparam int SW = fts_pkg::SHIFT_W;

    logic [fts_pkg::FACTOR_W-1:0] factor_reg;
    logic [fts_pkg::PRE_W-1:0]    pre_reg;

    logic load1, load2, load3, load4;

    // stage 1: decode
    logic          v1_reg, neg1_reg, sat1_reg, zero1_reg;
    logic [MW-1:0] mant1_reg;
    logic [SW-1:0] dsh1_reg, msh1_reg;

    // stage 2: align
    logic          v2_reg, neg2_reg, sat2_reg, zero2_reg;
    logic [MW-1:0] mag2_reg;
    logic [SW-1:0] dsh2_reg;

    // stage 3: multiply
    logic                        v3_reg, neg3_reg, sat3_reg, zero3_reg;
    logic [fts_pkg::PROD_W-1:0]  prod3_reg;
    logic [SW-1:0]               dsh3_reg;

    // stage 4: output
    logic                               v4_reg;
    logic signed [fts_pkg::NUM_W-1:0]   num4_reg;
    logic [fts_pkg::DIV_W-1:0]          div4_reg;

    logic signed [fts_pkg::EXP_W-1:0] expo_next;
    logic [5:0]                       sh_next;
    logic                             sat1_next, zero1_next;
    logic [SW-1:0]                    dsh1_next, msh1_next;
    logic [MW-1:0]                    mag2_next;
    logic [fts_pkg::PROD_W-1:0]       prod3_next;
    logic [fts_pkg::PROD_W-1:0]       scaled;
    logic [fts_pkg::MAG_W-1:0]        mag4;
    logic signed [fts_pkg::NUM_W-1:0] num4_next;
    logic [fts_pkg::DIV_W-1:0]        div4_next;

    assign load4 = !v4_reg || frac.ready;
    assign load3 = !v3_reg || load4;
    assign load2 = !v2_reg || load3;
    assign load1 = !v1_reg || load2;

    assign flt.ready      = load1;
    assign frac.valid     = v4_reg;
    assign frac.numerator = num4_reg;
    assign frac.divider   = div4_reg;

    always_comb
    begin
        expo_next = $signed({2'b00, flt.float_bits[30:23]})
                  - fts_pkg::EXP_W'(fts_pkg::EXP_BIAS)
                  + $signed({5'b00000, pre_reg});
        sat1_next  = expo_next > fts_pkg::EXP_W'(fts_pkg::EXP_LIMIT);
        zero1_next = expo_next < -fts_pkg::EXP_W'(fts_pkg::EXP_LIMIT);
        sh_next    = 6'(fts_pkg::EXP_W'(fts_pkg::EXP_LIMIT) - expo_next);
        if (sh_next >= 6'(fts_pkg::DIV_MAX_LOG2))
        begin
            dsh1_next = SW'(fts_pkg::DIV_MAX_LOG2);
            msh1_next = SW'(sh_next - 6'(fts_pkg::DIV_MAX_LOG2));
        end
        else
        begin
            dsh1_next = sh_next[SW-1:0];
            msh1_next = '0;
        end
    end

    assign mag2_next  = mant1_reg >> msh1_reg;
    assign prod3_next = fts_pkg::PROD_W'(mag2_reg) * fts_pkg::PROD_W'(factor_reg);

    always_comb
    begin
        scaled = prod3_reg >> pre_reg;
        if (sat3_reg)
        begin
            mag4 = fts_pkg::SAT_MAG;
        end
        else if (zero3_reg)
        begin
            mag4 = '0;
        end
        else
        begin
            mag4 = scaled[fts_pkg::MAG_W-1:0];
        end
        num4_next = neg3_reg ? -$signed({1'b0, mag4}) : $signed({1'b0, mag4});
        if (sat3_reg || zero3_reg)
        begin
            div4_next = fts_pkg::DIV_W'(1);
        end
        else
        begin
            div4_next = fts_pkg::DIV_W'(1) << dsh3_reg;
        end
    end

    // factor of 0 or 1 means no scaling; keep the multiplier at 1 then
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= fts_pkg::FACTOR_RESET;
            pre_reg    <= '0;
        end
        else if (cfg_we)
        begin
            factor_reg <= (fts_pkg::preshift_of(cfg_wdata) == '0) ?
                          fts_pkg::FACTOR_RESET : cfg_wdata;
            pre_reg    <= fts_pkg::preshift_of(cfg_wdata);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (load1)
            begin
                v1_reg <= flt.valid;
            end
            if (load2)
            begin
                v2_reg <= v1_reg;
            end
            if (load3)
            begin
                v3_reg <= v2_reg;
            end
            if (load4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            neg1_reg  <= flt.float_bits[31];
            sat1_reg  <= sat1_next;
            zero1_reg <= zero1_next;
            mant1_reg <= {1'b1, flt.float_bits[fts_pkg::FRAC_W-1:0]};
            dsh1_reg  <= dsh1_next;
            msh1_reg  <= msh1_next;
        end
        if (load2)
        begin
            neg2_reg  <= neg1_reg;
            sat2_reg  <= sat1_reg;
            zero2_reg <= zero1_reg;
            mag2_reg  <= mag2_next;
            dsh2_reg  <= dsh1_reg;
        end
        if (load3)
        begin
            neg3_reg  <= neg2_reg;
            sat3_reg  <= sat2_reg;
            zero3_reg <= zero2_reg;
            prod3_reg <= prod3_next;
            dsh3_reg  <= dsh2_reg;
        end
        if (load4)
        begin
            num4_reg <= num4_next;
            div4_reg <= div4_next;
        end
    end

endmodule

@@ rtl/fts_checker.sv @@
module fts_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [fts_pkg::NUM_W-1:0]  numerator,
    input logic [fts_pkg::DIV_W-1:0]         divider
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(numerator) && $stable(divider))
        else $error("output word changed while stalled");

    a_div_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot(divider))
        else $error("divider not a power of two");

    a_num_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divider != fts_pkg::DIV_W'(1) |-> numerator[25] == numerator[24])
        else $error("numerator magnitude out of range");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output stage");

endmodule

bind float32_to_scaled_fraction fts_checker u_fts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (flt.valid),
    .in_ready  (flt.ready),
    .out_valid (frac.valid),
    .out_ready (frac.ready),
    .numerator (frac.numerator),
    .divider   (frac.divider)
);

@@ sim/tb_top.sv @@
module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PER_PHASE = 126;
    localparam int PHASES = 13;

    localparam logic [fts_pkg::FLOAT_W-1:0] CORNER_WORDS [24] = '{
        32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
        32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000, 32'hFF80_0000,
        32'h7FC0_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7F7F_FFFF,
        32'h4B00_0000, 32'hCB7F_FFFF, 32'h4B80_0000, 32'h3400_0000,
        32'hB47F_FFFF, 32'h3380_0000, 32'h3C00_0000, 32'hBC80_0000,
        32'h3BFF_FFFF, 32'h3FFF_FFFF, 32'h5A5A_5A5A, 32'hA5A5_A5A5
    };

    localparam logic [fts_pkg::FACTOR_W-1:0] FIXED_FACTORS [8] = '{
        21'd0, 21'd1000, 21'd1048576, 21'd2, 21'd3, 21'd2097151, 21'd1, 21'd1024
    };

    typedef struct {
        logic signed [fts_pkg::NUM_W-1:0] numerator;
        logic [fts_pkg::DIV_W-1:0]        divider;
    } fraction_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic [fts_pkg::FACTOR_W-1:0] cfg_wdata;

    fts_in_if  flt_if ();
    fts_out_if frac_if ();

    float32_to_scaled_fraction dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .flt       (flt_if),
        .frac      (frac_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    logic [fts_pkg::FLOAT_W-1:0]  pending_words [$];
    fraction_t                    expected_fractions [$];
    logic [fts_pkg::FACTOR_W-1:0] scale_model;
    int                           error_count = 0;
    int                           gap_left = 0;
    int                           stall_left = 0;
    int                           quiet_cycles = 0;
    bit                           tx_burst = 0;
    bit                           rx_burst = 0;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic int ceil_log2_factor(input logic [fts_pkg::FACTOR_W-1:0] f);
        int top;
        top = 0;
        if (f <= 1)
        begin
            return 0;
        end
        for (int i = 0; i < fts_pkg::FACTOR_W; i++)
        begin
            if (f[i])
            begin
                top = i;
            end
        end
        if ((f & (f - 1'b1)) != '0)
        begin
            top++;
        end
        return top;
    endfunction

    function automatic fraction_t predict_fraction(input logic [fts_pkg::FLOAT_W-1:0] w,
                                                   input logic [fts_pkg::FACTOR_W-1:0] f);
        fraction_t  r;
        int         pre;
        int         expo;
        int         sh;
        logic [63:0] mag;
        logic [63:0] dv;
        pre  = ceil_log2_factor(f);
        expo = int'(w[30:23]) - fts_pkg::EXP_BIAS + pre;
        if (expo > fts_pkg::EXP_LIMIT)
        begin
            mag = 64'd1 << 24;
            dv  = 64'd1;
        end
        else if (expo < -fts_pkg::EXP_LIMIT)
        begin
            mag = '0;
            dv  = 64'd1;
        end
        else
        begin
            sh  = fts_pkg::EXP_LIMIT - expo;
            mag = {40'd0, 1'b1, w[fts_pkg::FRAC_W-1:0]};
            if (sh < fts_pkg::DIV_MAX_LOG2)
            begin
                dv = 64'd1 << sh;
            end
            else
            begin
                dv  = 64'd1 << fts_pkg::DIV_MAX_LOG2;
                mag = mag >> (sh - fts_pkg::DIV_MAX_LOG2);
            end
            if (pre > 0)
            begin
                mag = (mag * 64'(f)) >> pre;
            end
        end
        if (w[31])
        begin
            mag = -mag;
        end
        r.numerator = mag[fts_pkg::NUM_W-1:0];
        r.divider   = dv[fts_pkg::DIV_W-1:0];
        return r;
    endfunction

    // bias exponents toward the live range for the current preshift
    function automatic logic [fts_pkg::FLOAT_W-1:0] random_float(input int pre);
        logic [fts_pkg::FLOAT_W-1:0] w;
        int                          biased;
        int                          limit_exps [7];
        limit_exps = '{-24, -23, -8, -7, -6, 23, 24};
        w = $urandom;
        biased = fts_pkg::EXP_BIAS - pre + $urandom_range(0, 52) - 26;
        case ($urandom_range(0, 9))
            6: biased = w[30:23];
            7: biased = $urandom_range(0, 1) ? 0 : 255;
            8: biased = fts_pkg::EXP_BIAS - pre + limit_exps[$urandom_range(0, 6)];
            9: w[fts_pkg::FRAC_W-1:0] = $urandom_range(0, 1) ? '0 : '1;
            default: ;
        endcase
        w[30:23] = biased[7:0];
        return w;
    endfunction

    task automatic write_scale(input logic [fts_pkg::FACTOR_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        scale_model = value;
    endtask

    task automatic settle();
        while (pending_words.size() != 0 || flt_if.valid || expected_fractions.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            flt_if.valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (flt_if.valid && flt_if.ready)
            begin
                expected_fractions.push_back(predict_fraction(flt_if.float_bits, scale_model));
            end
            if (!flt_if.valid || flt_if.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    flt_if.valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    flt_if.valid      <= 1'b1;
                    flt_if.float_bits <= pending_words.pop_front();
                    gap_left = tx_burst ? 0 : $urandom_range(0, 8);
                    if ($urandom_range(0, 63) == 0)
                    begin
                        tx_burst = !tx_burst;
                    end
                end
                else
                begin
                    flt_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        fraction_t want;
        if (!rst_n)
        begin
            frac_if.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (frac_if.valid && frac_if.ready)
            begin
                if (expected_fractions.size() == 0)
                begin
                    $error("numerator: no word expected, got %0d", frac_if.numerator);
                    error_count++;
                end
                else
                begin
                    want = expected_fractions.pop_front();
                    if (frac_if.numerator !== want.numerator)
                    begin
                        $error("numerator: expected %0d, got %0d",
                               want.numerator, frac_if.numerator);
                        error_count++;
                    end
                    if (frac_if.divider !== want.divider)
                    begin
                        $error("divider: expected %0d, got %0d", want.divider, frac_if.divider);
                        error_count++;
                    end
                end
                stall_left = rx_burst ? 0 : $urandom_range(0, 8);
                if ($urandom_range(0, 63) == 0)
                begin
                    rx_burst = !rx_burst;
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                frac_if.ready <= 1'b0;
            end
            else
            begin
                frac_if.ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((flt_if.valid && flt_if.ready) || (frac_if.valid && frac_if.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [fts_pkg::FACTOR_W-1:0] f;
        int                           pre;
        flt_if.valid      = 1'b0;
        flt_if.float_bits = '0;
        frac_if.ready     = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = fts_pkg::FACTOR_RESET;
        scale_model       = fts_pkg::FACTOR_RESET;
        rst_n             = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                if (phase <= 8)
                begin
                    f = FIXED_FACTORS[phase - 1];
                end
                else if ($urandom_range(0, 1) == 0)
                begin
                    f = fts_pkg::FACTOR_W'($urandom_range(2, 4096));
                end
                else
                begin
                    f = fts_pkg::FACTOR_W'($urandom_range(4097, 2097151));
                end
                write_scale(f);
            end
            pre = ceil_log2_factor(scale_model);
            foreach (CORNER_WORDS[i])
            begin
                pending_words.push_back(CORNER_WORDS[i]);
            end
            repeat (RANDOM_PER_PHASE) pending_words.push_back(random_float(pre));
            // sender holds here until every word has come back
            settle();
        end
        if (error_count == 0 && expected_fractions.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
